FILE: hw/rtl/rmq_pkg.sv
// Shared constants and types for the rotation matrix to quaternion pipeline.
// No dependencies; every other file in hw/rtl imports this package.
package rmq_pkg;

  // Pipeline depth of the square root and divider units (one bit per stage).
  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS  = 64;

  // Width of a normalised element in Q2.30 (unscaled rows reach 2^45).
  localparam int NW = 48;
  // Width of traces, radicands and numerators before the second root.
  localparam int RW = 50;

  // Register loads from the input capture to the result register.
  localparam int PIPE_LAT = 2 * SQRT_STEPS + 2 * DIV_STEPS + 9;

  // Smallest Q16.16 row length that is above 0.0001.
  localparam logic [31:0] SCALE_MIN = 32'd7;

  // One in Q2.30.
  localparam logic signed [RW-1:0] Q30_ONE = RW'(64'sd1073741824);

  // Which quaternion component comes straight from the square root.
  typedef enum logic [3:0] {
    BR_W = 4'b0001,
    BR_X = 4'b0010,
    BR_Y = 4'b0100,
    BR_Z = 4'b1000
  } branch_t;

endpackage

FILE: hw/rtl/rmq_sqrt.sv
// Pipelined integer square root, floor(sqrt(x)) of a 64-bit value.
// One result bit per register stage; depends on rmq_pkg.
module rmq_sqrt import rmq_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic [63:0] radicand,
  output logic        out_valid,
  output logic [31:0] root
);

  logic        vld_q  [SQRT_STEPS];
  logic [63:0] rad_q  [SQRT_STEPS];
  logic [33:0] rem_q  [SQRT_STEPS];
  logic [31:0] res_q  [SQRT_STEPS];

  logic        vld_in [SQRT_STEPS];
  logic [63:0] rad_in [SQRT_STEPS];
  logic [33:0] rem_in [SQRT_STEPS];
  logic [31:0] res_in [SQRT_STEPS];
  logic [35:0] trial  [SQRT_STEPS];
  logic [35:0] diff   [SQRT_STEPS];
  logic [33:0] tst    [SQRT_STEPS];
  logic        ge     [SQRT_STEPS];

  always_comb begin
    vld_in[0] = in_valid;
    rad_in[0] = radicand;
    rem_in[0] = '0;
    res_in[0] = '0;
    for (int s = 1; s < SQRT_STEPS; s++) begin
      vld_in[s] = vld_q[s-1];
      rad_in[s] = rad_q[s-1];
      rem_in[s] = rem_q[s-1];
      res_in[s] = res_q[s-1];
    end
    // Bring down the next two radicand bits and try the digit one.
    for (int s = 0; s < SQRT_STEPS; s++) begin
      trial[s] = {rem_in[s], rad_in[s][63:62]};
      tst[s]   = {res_in[s], 2'b01};
      ge[s]    = trial[s] >= {2'b00, tst[s]};
      diff[s]  = trial[s] - {2'b00, tst[s]};
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < SQRT_STEPS; s++) begin
      if (rst) begin
        vld_q[s] <= 1'b0;
      end else begin
        vld_q[s] <= vld_in[s];
      end
      rad_q[s] <= {rad_in[s][61:0], 2'b00};
      rem_q[s] <= ge[s] ? diff[s][33:0] : trial[s][33:0];
      res_q[s] <= {res_in[s][30:0], ge[s]};
    end
  end

  assign out_valid = vld_q[SQRT_STEPS-1];
  assign root      = res_q[SQRT_STEPS-1];

endmodule

FILE: hw/rtl/rmq_div.sv
// Pipelined restoring divider, 64-bit dividend by 33-bit divisor.
// One quotient bit per register stage; depends on rmq_pkg.
module rmq_div import rmq_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic [63:0] dividend,
  input  logic [32:0] divisor,
  output logic        out_valid,
  output logic [63:0] quotient
);

  logic        vld_q  [DIV_STEPS];
  logic [63:0] num_q  [DIV_STEPS];
  logic [32:0] rem_q  [DIV_STEPS];
  logic [32:0] dvs_q  [DIV_STEPS];

  logic        vld_in [DIV_STEPS];
  logic [63:0] num_in [DIV_STEPS];
  logic [32:0] rem_in [DIV_STEPS];
  logic [32:0] dvs_in [DIV_STEPS];
  logic [33:0] trial  [DIV_STEPS];
  logic [33:0] diff   [DIV_STEPS];
  logic        ge     [DIV_STEPS];

  always_comb begin
    vld_in[0] = in_valid;
    num_in[0] = dividend;
    rem_in[0] = '0;
    dvs_in[0] = divisor;
    for (int s = 1; s < DIV_STEPS; s++) begin
      vld_in[s] = vld_q[s-1];
      num_in[s] = num_q[s-1];
      rem_in[s] = rem_q[s-1];
      dvs_in[s] = dvs_q[s-1];
    end
    for (int s = 0; s < DIV_STEPS; s++) begin
      trial[s] = {rem_in[s], num_in[s][63]};
      ge[s]    = trial[s] >= {1'b0, dvs_in[s]};
      diff[s]  = trial[s] - {1'b0, dvs_in[s]};
    end
  end

  // The dividend shifts out at the top while quotient bits shift in below.
  always_ff @(posedge clk) begin
    for (int s = 0; s < DIV_STEPS; s++) begin
      if (rst) begin
        vld_q[s] <= 1'b0;
      end else begin
        vld_q[s] <= vld_in[s];
      end
      num_q[s] <= {num_in[s][62:0], ge[s]};
      rem_q[s] <= ge[s] ? diff[s][32:0] : trial[s][32:0];
      dvs_q[s] <= dvs_in[s];
    end
  end

  assign out_valid = vld_q[DIV_STEPS-1];
  assign quotient  = num_q[DIV_STEPS-1];

endmodule

FILE: hw/rtl/rotation_matrix_to_quaternion.sv
// Top level: rotation matrix (Q16.16) to unit quaternion (Q2.30), fully pipelined.
// Depends on rmq_pkg, rmq_sqrt and rmq_div.
//
//   channel  ports                              transfer
//   matrix   start, busy, m00 .. m22            start high while busy low
//   result   done, qw, qx, qy, qz               done high for one cycle
//
// One matrix may be transferred in every clock cycle; busy stays low.
// Each result passes from its matrix through two 32-stage square roots
// and two 64-stage dividers in series.
// A synchronous reset empties the pipeline; items in flight are dropped.
// The receiver cannot stall, so the pipeline never stops.
module rotation_matrix_to_quaternion import rmq_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] m00,
  input  logic [31:0] m01,
  input  logic [31:0] m02,
  input  logic [31:0] m10,
  input  logic [31:0] m11,
  input  logic [31:0] m12,
  input  logic [31:0] m20,
  input  logic [31:0] m21,
  input  logic [31:0] m22,
  output logic        done,
  output logic [31:0] qw,
  output logic [31:0] qx,
  output logic [31:0] qy,
  output logic [31:0] qz
);

  // Side information that rides alongside the second divider.
  typedef struct packed {
    logic [2:0]  neg;
    logic [31:0] half;
    logic        zero;
    branch_t     br;
  } fin_t;

  function automatic logic [31:0] mag32(input logic [31:0] v);
    return v[31] ? (32'd0 - v) : v;
  endfunction

  function automatic logic [31:0] sat64(input logic signed [63:0] v);
    if (v > 64'sh0000_0000_7FFF_FFFF) begin
      return 32'h7FFF_FFFF;
    end else if (v < -64'sh0000_0000_8000_0000) begin
      return 32'h8000_0000;
    end else begin
      return v[31:0];
    end
  endfunction

  // The block takes a matrix in every cycle.
  assign busy = 1'b0;

  logic [31:0] in_e [9];
  assign in_e[0] = m00;
  assign in_e[1] = m01;
  assign in_e[2] = m02;
  assign in_e[3] = m10;
  assign in_e[4] = m11;
  assign in_e[5] = m12;
  assign in_e[6] = m20;
  assign in_e[7] = m21;
  assign in_e[8] = m22;

  // ---------------------------------------------------------------------
  // Row lengths: capture, square each element, add up each row.
  // ---------------------------------------------------------------------
  logic        a_vld, b_vld, c_vld;
  logic [31:0] a_e [9];
  logic [31:0] b_e [9];
  logic [31:0] c_e [9];
  logic [63:0] b_sq [9];
  logic [63:0] c_sum [3];
  logic [31:0] a_mag [9];

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      a_mag[k] = mag32(a_e[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
      b_vld <= 1'b0;
      c_vld <= 1'b0;
    end else begin
      a_vld <= start && !busy;
      b_vld <= a_vld;
      c_vld <= b_vld;
    end
    a_e <= in_e;
    b_e <= a_e;
    c_e <= b_e;
    for (int k = 0; k < 9; k++) begin
      b_sq[k] <= {32'd0, a_mag[k]} * {32'd0, a_mag[k]};
    end
    // Three squares of at most 2^62 each cannot overflow 64 bits.
    for (int i = 0; i < 3; i++) begin
      c_sum[i] <= b_sq[3*i] + b_sq[3*i+1] + b_sq[3*i+2];
    end
  end

  logic        len_vld [3];
  logic [31:0] len [3];

  for (genvar i = 0; i < 3; i++) begin : g_len
    rmq_sqrt u_len (
      .clk      (clk),
      .rst      (rst),
      .in_valid (c_vld),
      .radicand (c_sum[i]),
      .out_valid(len_vld[i]),
      .root     (len[i])
    );
  end

  logic [31:0] e_dl1 [SQRT_STEPS][9];

  always_ff @(posedge clk) begin
    e_dl1[0] <= c_e;
    for (int s = 1; s < SQRT_STEPS; s++) begin
      e_dl1[s] <= e_dl1[s-1];
    end
  end

  // ---------------------------------------------------------------------
  // Row normalisation: each element divided by its row length, rounded
  // half away from zero. Rows shorter than the threshold pass unscaled.
  // ---------------------------------------------------------------------
  logic        d_vld;
  logic [63:0] d_dvd [9];
  logic [32:0] d_dvs [9];
  logic [2:0]  d_norm;
  logic [31:0] d_e [9];

  always_ff @(posedge clk) begin
    if (rst) begin
      d_vld <= 1'b0;
    end else begin
      d_vld <= len_vld[0];
    end
    for (int k = 0; k < 9; k++) begin
      d_dvd[k] <= {2'b00, mag32(e_dl1[SQRT_STEPS-1][k]), 30'd0}
                + {33'd0, len[k/3][31:1]};
      d_dvs[k] <= {1'b0, len[k/3]};
    end
    for (int i = 0; i < 3; i++) begin
      d_norm[i] <= len[i] >= SCALE_MIN;
    end
    d_e <= e_dl1[SQRT_STEPS-1];
  end

  logic        q1_vld [9];
  logic [63:0] q1 [9];

  for (genvar k = 0; k < 9; k++) begin : g_norm
    rmq_div u_norm (
      .clk      (clk),
      .rst      (rst),
      .in_valid (d_vld),
      .dividend (d_dvd[k]),
      .divisor  (d_dvs[k]),
      .out_valid(q1_vld[k]),
      .quotient (q1[k])
    );
  end

  logic [31:0] e_dl2 [DIV_STEPS][9];
  logic [2:0]  norm_dl2 [DIV_STEPS];

  always_ff @(posedge clk) begin
    e_dl2[0]    <= d_e;
    norm_dl2[0] <= d_norm;
    for (int s = 1; s < DIV_STEPS; s++) begin
      e_dl2[s]    <= e_dl2[s-1];
      norm_dl2[s] <= norm_dl2[s-1];
    end
  end

  logic                 e_vld;
  logic signed [NW-1:0] e_n [9];
  logic signed [NW-1:0] q1_s [9];
  logic signed [NW-1:0] raw_s [9];

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      q1_s[k]  = q1[k][NW-1:0];
      raw_s[k] = {{(NW-46){e_dl2[DIV_STEPS-1][k][31]}}, e_dl2[DIV_STEPS-1][k], 14'd0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e_vld <= 1'b0;
    end else begin
      e_vld <= q1_vld[0];
    end
    for (int k = 0; k < 9; k++) begin
      if (norm_dl2[DIV_STEPS-1][k/3]) begin
        e_n[k] <= e_dl2[DIV_STEPS-1][k][31] ? -q1_s[k] : q1_s[k];
      end else begin
        e_n[k] <= raw_s[k];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Branch choice: positive trace, else the largest diagonal element.
  // The three numerators are kept in component order, skipping the one
  // that comes from the square root.
  // ---------------------------------------------------------------------
  logic signed [RW-1:0] n [9];
  logic signed [RW-1:0] tr;
  logic                 big_x, big_y;
  logic signed [RW-1:0] f_rad_next;
  logic signed [RW-1:0] f_num_next [3];
  branch_t              f_br_next;

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      n[k] = RW'(e_n[k]);
    end
    tr    = n[0] + n[4] + n[8];
    big_x = (n[0] > n[4]) && (n[0] > n[8]);
    big_y = n[4] > n[8];
    if (tr > 0) begin
      f_br_next     = BR_W;
      f_rad_next    = Q30_ONE + tr;
      f_num_next[0] = n[7] - n[5];
      f_num_next[1] = n[2] - n[6];
      f_num_next[2] = n[3] - n[1];
    end else if (big_x) begin
      f_br_next     = BR_X;
      f_rad_next    = Q30_ONE + n[0] - n[4] - n[8];
      f_num_next[0] = n[7] - n[5];
      f_num_next[1] = n[1] + n[3];
      f_num_next[2] = n[2] + n[6];
    end else if (big_y) begin
      f_br_next     = BR_Y;
      f_rad_next    = Q30_ONE + n[4] - n[0] - n[8];
      f_num_next[0] = n[2] - n[6];
      f_num_next[1] = n[1] + n[3];
      f_num_next[2] = n[5] + n[7];
    end else begin
      f_br_next     = BR_Z;
      f_rad_next    = Q30_ONE + n[8] - n[0] - n[4];
      f_num_next[0] = n[3] - n[1];
      f_num_next[1] = n[2] + n[6];
      f_num_next[2] = n[5] + n[7];
    end
  end

  logic                 f_vld, g_vld;
  logic signed [RW-1:0] f_rad;
  logic signed [RW-1:0] f_num [3];
  branch_t              f_br;
  logic [63:0]          g_rad;
  logic signed [RW-1:0] g_num [3];
  branch_t              g_br;
  logic signed [RW-1:0] rad_clamp;

  // A radicand below one is taken as one; the shift by 30 keeps only the
  // low 64 bits of the product.
  assign rad_clamp = (f_rad < Q30_ONE) ? Q30_ONE : f_rad;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_vld <= 1'b0;
      g_vld <= 1'b0;
    end else begin
      f_vld <= e_vld;
      g_vld <= f_vld;
    end
    f_rad <= f_rad_next;
    f_num <= f_num_next;
    f_br  <= f_br_next;
    g_rad <= {rad_clamp[33:0], 30'd0};
    g_num <= f_num;
    g_br  <= f_br;
  end

  logic        r_vld;
  logic [31:0] r;

  rmq_sqrt u_root (
    .clk      (clk),
    .rst      (rst),
    .in_valid (g_vld),
    .radicand (g_rad),
    .out_valid(r_vld),
    .root     (r)
  );

  logic signed [RW-1:0] num_dl3 [SQRT_STEPS][3];
  branch_t              br_dl3 [SQRT_STEPS];

  always_ff @(posedge clk) begin
    num_dl3[0] <= g_num;
    br_dl3[0]  <= g_br;
    for (int s = 1; s < SQRT_STEPS; s++) begin
      num_dl3[s] <= num_dl3[s-1];
      br_dl3[s]  <= br_dl3[s-1];
    end
  end

  // ---------------------------------------------------------------------
  // Remaining components: numerator over twice the root, rounded. As in
  // the 64-bit arithmetic, the scaled numerator wraps modulo 2^64.
  // ---------------------------------------------------------------------
  logic        h_vld;
  logic [63:0] h_dvd [3];
  logic [32:0] h_dvs;
  fin_t        h_fin;
  logic [RW-1:0] num_mag [3];
  logic [32:0]   r_inc;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      num_mag[k] = num_dl3[SQRT_STEPS-1][k][RW-1]
                 ? (RW'(0) - num_dl3[SQRT_STEPS-1][k])
                 : num_dl3[SQRT_STEPS-1][k];
    end
    r_inc = {1'b0, r} + 33'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      h_vld <= 1'b0;
    end else begin
      h_vld <= r_vld;
    end
    for (int k = 0; k < 3; k++) begin
      h_dvd[k]     <= {num_mag[k][33:0], 30'd0} + {32'd0, r};
      h_fin.neg[k] <= num_dl3[SQRT_STEPS-1][k][RW-1];
    end
    h_dvs      <= {r, 1'b0};
    h_fin.half <= r_inc[32:1];
    h_fin.zero <= r == 32'd0;
    h_fin.br   <= br_dl3[SQRT_STEPS-1];
  end

  logic        q2_vld [3];
  logic [63:0] q2 [3];

  for (genvar k = 0; k < 3; k++) begin : g_comp
    rmq_div u_comp (
      .clk      (clk),
      .rst      (rst),
      .in_valid (h_vld),
      .dividend (h_dvd[k]),
      .divisor  (h_dvs),
      .out_valid(q2_vld[k]),
      .quotient (q2[k])
    );
  end

  fin_t fin_dl4 [DIV_STEPS];

  always_ff @(posedge clk) begin
    fin_dl4[0] <= h_fin;
    for (int s = 1; s < DIV_STEPS; s++) begin
      fin_dl4[s] <= fin_dl4[s-1];
    end
  end

  // ---------------------------------------------------------------------
  // Sign, saturation and placement of the four components.
  // ---------------------------------------------------------------------
  fin_t        fin;
  logic [31:0] comp [3];
  logic [31:0] half_s;
  logic [63:0] sgn [3];
  logic [31:0] qw_next, qx_next, qy_next, qz_next;

  assign fin = fin_dl4[DIV_STEPS-1];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sgn[k]  = fin.neg[k] ? (64'd0 - q2[k]) : q2[k];
      comp[k] = fin.zero ? 32'd0 : sat64(sgn[k]);
    end
    half_s = fin.half[31] ? 32'h7FFF_FFFF : fin.half;
    unique case (fin.br)
      BR_W: begin
        qw_next = half_s;  qx_next = comp[0]; qy_next = comp[1]; qz_next = comp[2];
      end
      BR_X: begin
        qw_next = comp[0]; qx_next = half_s;  qy_next = comp[1]; qz_next = comp[2];
      end
      BR_Y: begin
        qw_next = comp[0]; qx_next = comp[1]; qy_next = half_s;  qz_next = comp[2];
      end
      BR_Z: begin
        qw_next = comp[0]; qx_next = comp[1]; qy_next = comp[2]; qz_next = half_s;
      end
      default: begin
        qw_next = '0;      qx_next = '0;      qy_next = '0;      qz_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= q2_vld[0];
    end
    qw <= qw_next;
    qx <= qx_next;
    qy <= qy_next;
    qz <= qz_next;
  end

`ifndef ASSERT_OFF
  // Every result goes back to a matrix transferred a fixed time earlier.
  a_done_has_item: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, PIPE_LAT))
    else $error("result without a matching input transfer");

  // A reset leaves nothing in flight.
  a_reset_flush: assert property (@(posedge clk)
    rst |=> !done)
    else $error("result strobe straight after reset");

  // On the positive-trace branch the scalar part comes from the root.
  a_w_nonneg: assert property (@(posedge clk) disable iff (rst)
    (q2_vld[0] && fin.br == BR_W) |=> (done && !qw[31]))
    else $error("scalar part negative on the trace branch");
`endif

endmodule
